// ===== src/e2q_pkg.sv =====
// Package for the Euler-to-quaternion block: CORDIC constants and the
// arctangent table. No dependencies.
package e2q_pkg;
    localparam int unsigned TableLen = 30;
    localparam logic [31:0] HalfDegToPhase = 32'd3054198966;
    localparam logic signed [33:0] CordicStart = 34'sd652032875;

    function automatic logic [31:0] atan_phase(input logic [4:0] idx);
        logic [31:0] v;
        begin
            case (idx)
                5'd0: v = 32'd536870912;
                5'd1: v = 32'd316933406;
                5'd2: v = 32'd167458907;
                5'd3: v = 32'd85004756;
                5'd4: v = 32'd42667331;
                5'd5: v = 32'd21354465;
                5'd6: v = 32'd10679838;
                5'd7: v = 32'd5340245;
                5'd8: v = 32'd2670163;
                5'd9: v = 32'd1335087;
                5'd10: v = 32'd667544;
                5'd11: v = 32'd333772;
                5'd12: v = 32'd166886;
                5'd13: v = 32'd83443;
                5'd14: v = 32'd41722;
                5'd15: v = 32'd20861;
                5'd16: v = 32'd10430;
                5'd17: v = 32'd5215;
                5'd18: v = 32'd2608;
                5'd19: v = 32'd1304;
                5'd20: v = 32'd652;
                5'd21: v = 32'd326;
                5'd22: v = 32'd163;
                5'd23: v = 32'd81;
                5'd24: v = 32'd41;
                5'd25: v = 32'd20;
                5'd26: v = 32'd10;
                5'd27: v = 32'd5;
                5'd28: v = 32'd3;
                5'd29: v = 32'd1;
                default: v = 32'd0;
            endcase
            return v;
        end
    endfunction

    // CORDIC vector of one angle; t_rot3 holds the three that travel from cell to cell.
    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [32:0] z;
        logic               flip;
    } t_rot;

    typedef t_rot [2:0] t_rot3;

    // Q30 rounded product, half up.
    function automatic logic signed [33:0] mul_q30(input logic signed [33:0] a,
                                                   input logic signed [33:0] b);
        logic signed [67:0] p;
        begin
            p = a * b + 68'sd536870912;
            return p[63:30];
        end
    endfunction
endpackage

// ===== src/euler_to_quaternion.sv =====
// Top level of the Euler-to-quaternion block: phase conversion, a chain of
// CORDIC cells, product stages and the output register. Depends on e2q_pkg
// and e2q_cell.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  angles  | i_valid, o_ready, i_roll/pitch/yaw_deg     | in
//  quat    | o_valid, i_ready, o_quat_w/x/y/z           | out
//
// One request enters per cycle unless the pipeline holds. The stages are, in
// order: one for phase conversion, one per CORDIC cell, two for the pair
// products, one for the triple products, one for the sums and one for the output.
// The whole pipeline advances together; it holds when the output register
// is full and not being taken, so o_ready is low only in that case.
// Reset clears the valid bits only; data registers are not reset.
module euler_to_quaternion import e2q_pkg::*; #(
    parameter int unsigned ANGLE_WIDTH   = 16,
    parameter int unsigned OUT_WIDTH     = 16,
    parameter int unsigned CORDIC_STAGES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [ANGLE_WIDTH-1:0] i_roll_deg,
    input  logic signed [ANGLE_WIDTH-1:0] i_pitch_deg,
    input  logic signed [ANGLE_WIDTH-1:0] i_yaw_deg,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [OUT_WIDTH-1:0]   o_quat_w,
    output logic signed [OUT_WIDTH-1:0]   o_quat_x,
    output logic signed [OUT_WIDTH-1:0]   o_quat_y,
    output logic signed [OUT_WIDTH-1:0]   o_quat_z
);
    // Stages beyond the table length are not performed.
    localparam int unsigned NStg = (CORDIC_STAGES < TableLen) ? CORDIC_STAGES : TableLen;

    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // Phase conversion: degrees times a constant gives a 32-bit binary angle
    // of the half angle. Quadrants 1 and 2 are folded by half a turn.
    logic signed [ANGLE_WIDTH-1:0] ang [3];
    t_rot3 n_rot0, r_rot0;
    logic  r_vld0;
    assign ang[0] = i_roll_deg;
    assign ang[1] = i_pitch_deg;
    assign ang[2] = i_yaw_deg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic [63:0] prod;
            logic [31:0] p;
            logic        fl;
            prod = 64'($signed(ang[k])) * {32'd0, HalfDegToPhase} + 64'd32768;
            p  = prod[47:16];
            fl = p[31] ^ p[30];
            if (fl) begin
                p = p + 32'h8000_0000;
            end
            n_rot0[k].x    = CordicStart;
            n_rot0[k].y    = '0;
            n_rot0[k].z    = $signed({p[31], p});
            n_rot0[k].flip = fl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else if (en) begin
            r_vld0 <= i_valid;
        end
        if (en) begin
            r_rot0 <= n_rot0;
        end
    end

    // Chain of CORDIC cells.
    t_rot3 chain_rot [NStg+1];
    logic  chain_vld [NStg+1];
    assign chain_rot[0] = r_rot0;
    assign chain_vld[0] = r_vld0;

    for (genvar g = 0; g < NStg; g++) begin : g_cell
        e2q_cell #(.STAGE(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_vld  (chain_vld[g]),
            .i_rot  (chain_rot[g]),
            .o_vld  (chain_vld[g+1]),
            .o_rot  (chain_rot[g+1])
        );
    end

    // Undo the fold and form the pair products.
    logic signed [33:0] cs [3];
    logic signed [33:0] sn [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            cs[k] = chain_rot[NStg][k].flip ? -chain_rot[NStg][k].x : chain_rot[NStg][k].x;
            sn[k] = chain_rot[NStg][k].flip ? -chain_rot[NStg][k].y : chain_rot[NStg][k].y;
        end
    end

    // Stage A: register cos/sin. Stage B: pair products cr*cp etc.
    logic signed [33:0] r_cs [3];
    logic signed [33:0] r_sn [3];
    logic               r_vld_a, r_vld_b, r_vld_c, r_vld_d;
    logic signed [33:0] r_crcp, r_srsp, r_srcp, r_crsp, r_cy, r_sy;
    logic signed [33:0] r_t [8];
    logic signed [34:0] r_sum [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
            r_vld_d <= 1'b0;
        end else if (en) begin
            r_vld_a <= chain_vld[NStg];
            r_vld_b <= r_vld_a;
            r_vld_c <= r_vld_b;
            r_vld_d <= r_vld_c;
        end
        if (en) begin
            r_cs   <= cs;
            r_sn   <= sn;
            r_crcp <= mul_q30(r_cs[0], r_cs[1]);
            r_srsp <= mul_q30(r_sn[0], r_sn[1]);
            r_srcp <= mul_q30(r_sn[0], r_cs[1]);
            r_crsp <= mul_q30(r_cs[0], r_sn[1]);
            r_cy   <= r_cs[2];
            r_sy   <= r_sn[2];
            r_t[0] <= mul_q30(r_crcp, r_cy);
            r_t[1] <= mul_q30(r_srsp, r_sy);
            r_t[2] <= mul_q30(r_srcp, r_cy);
            r_t[3] <= mul_q30(r_crsp, r_sy);
            r_t[4] <= mul_q30(r_crsp, r_cy);
            r_t[5] <= mul_q30(r_srcp, r_sy);
            r_t[6] <= mul_q30(r_crcp, r_sy);
            r_t[7] <= mul_q30(r_srsp, r_cy);
            r_sum[0] <= 35'(r_t[0]) + 35'(r_t[1]);
            r_sum[1] <= 35'(r_t[2]) - 35'(r_t[3]);
            r_sum[2] <= 35'(r_t[4]) + 35'(r_t[5]);
            r_sum[3] <= 35'(r_t[6]) - 35'(r_t[7]);
        end
    end

    // Output rounding and saturation.
    localparam logic signed [35:0] MaxV = 36'sd1 <<< (OUT_WIDTH - 1);
    logic signed [OUT_WIDTH-1:0] q [4];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            logic signed [35:0] r;
            if (OUT_WIDTH < 31) begin
                r = (36'(r_sum[k]) + (36'sd1 <<< (30 - OUT_WIDTH))) >>> (31 - OUT_WIDTH);
            end else if (OUT_WIDTH > 31) begin
                r = 36'(r_sum[k]) <<< 1;
            end else begin
                r = 36'(r_sum[k]);
            end
            if (r > MaxV - 36'sd1) begin
                r = MaxV - 36'sd1;
            end else if (r < -MaxV) begin
                r = -MaxV;
            end
            q[k] = r[OUT_WIDTH-1:0];
        end
    end

    logic r_ovld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (en) begin
            r_ovld <= r_vld_d;
        end
        if (en) begin
            o_quat_w <= q[0];
            o_quat_x <= q[1];
            o_quat_y <= q[2];
            o_quat_z <= q[3];
        end
    end
    assign o_valid = r_ovld;
endmodule

// ===== src/e2q_cell.sv =====
// One CORDIC rotation cell for all three angles, with one valid bit.
// Depends on e2q_pkg.
module e2q_cell import e2q_pkg::*; #(
    parameter int unsigned STAGE = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_vld,
    input  t_rot3 i_rot,
    output logic  o_vld,
    output t_rot3 o_rot
);
    localparam logic [4:0] Idx = 5'(STAGE);
    logic [31:0] atn;
    t_rot3 n_rot, r_rot;
    logic  r_vld;

    assign atn = atan_phase(Idx);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_rot[k].flip = i_rot[k].flip;
            if (!i_rot[k].z[32]) begin
                n_rot[k].x = i_rot[k].x - (i_rot[k].y >>> STAGE);
                n_rot[k].y = i_rot[k].y + (i_rot[k].x >>> STAGE);
                n_rot[k].z = i_rot[k].z - $signed({1'b0, atn});
            end else begin
                n_rot[k].x = i_rot[k].x + (i_rot[k].y >>> STAGE);
                n_rot[k].y = i_rot[k].y - (i_rot[k].x >>> STAGE);
                n_rot[k].z = i_rot[k].z + $signed({1'b0, atn});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
        if (i_en) begin
            r_rot <= n_rot;
        end
    end

    assign o_vld = r_vld;
    assign o_rot = r_rot;
endmodule

// ===== src/e2q_checker.sv =====
// Port-level checker for euler_to_quaternion, with its bind statement.
// Depends on the top level's ports only.
module e2q_checker #(
    parameter int unsigned OUT_WIDTH = 16
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_ready,
    input logic                 o_valid,
    input logic                 i_ready,
    input logic [OUT_WIDTH-1:0] o_quat_w
);
    // The pipeline stalls only when a result waits.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready)) else $error("stall without backpressure");
    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_quat_w)))
        else $error("result changed under stall");
    // No result right after reset.
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");
endmodule

bind euler_to_quaternion e2q_checker #(.OUT_WIDTH(OUT_WIDTH)) u_e2q_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_quat_w(o_quat_w)
);

// ===== tb/sv/euler_to_quaternion_test.sv =====
// Self-checking testbench for euler_to_quaternion: drives roll/pitch/yaw requests
// with random idling on both sides and checks each quaternion against a bit-exact
// predictor. Depends on e2q_pkg and the euler_to_quaternion RTL.
module euler_to_quaternion_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AngW = 16;
    localparam int OutW = 16;
    localparam int Stages = 16;
    localparam int NumRandom = 630;

    typedef struct packed {
        logic signed [AngW-1:0] roll;
        logic signed [AngW-1:0] pitch;
        logic signed [AngW-1:0] yaw;
    } t_angles;

    typedef struct packed {
        logic signed [OutW-1:0] w;
        logic signed [OutW-1:0] x;
        logic signed [OutW-1:0] y;
        logic signed [OutW-1:0] z;
    } t_quat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    logic o_ready, o_valid;
    logic signed [AngW-1:0] i_roll_deg = '0, i_pitch_deg = '0, i_yaw_deg = '0;
    logic signed [OutW-1:0] o_quat_w, o_quat_x, o_quat_y, o_quat_z;

    t_angles pending_angles[$];
    t_quat   expected_quats[$];
    int      mismatches = 0;
    int      quats_checked = 0;
    int      requests_sent = 0;
    bit      stimulus_done = 0;
    bit      calm_stretch = 0;

    euler_to_quaternion #(
        .ANGLE_WIDTH(AngW), .OUT_WIDTH(OutW), .CORDIC_STAGES(Stages)
    ) DUT (.*);

    // Clock: 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Arctangent of 2^-i in binary-angle units (2^32 is one turn).
    function automatic longint atan_step(int i);
        longint tbl[30] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
            83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41,
            20, 10, 5, 3, 1};
        return tbl[i];
    endfunction

    // Cosine and sine (Q30) of half the angle, by a rotation-mode CORDIC.
    function automatic void half_angle_cos_sin(input logic signed [AngW-1:0] deg,
                                               output longint c, output longint s);
        logic [63:0] prod;
        logic [31:0] phase;
        bit          flip;
        longint      x, y, z, dx, dy;
        prod = 64'($signed(deg)) * 64'd3054198966 + 64'd32768;
        phase = prod[47:16];
        // Quadrants one and two are folded by half a turn and negated afterward.
        flip = (phase[31:30] == 2'd1) || (phase[31:30] == 2'd2);
        if (flip) phase = phase + 32'h8000_0000;
        x = 652032875;
        y = 0;
        z = longint'($signed(phase));
        for (int i = 0; i < Stages && i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_step(i);
            end else begin
                x += dx; y -= dy; z += atan_step(i);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint round_q30(longint a, longint b);
        return (a * b + (longint'(1) << 29)) >>> 30;
    endfunction

    function automatic logic signed [OutW-1:0] to_q15(longint q30);
        longint r, hi, lo;
        hi = (longint'(1) << (OutW - 1)) - 1;
        lo = -hi - 1;
        r = (q30 + (longint'(1) << (30 - OutW))) >>> (31 - OutW);
        if (r > hi) r = hi;
        if (r < lo) r = lo;
        return r[OutW-1:0];
    endfunction

    function automatic t_quat predict_quat(t_angles a);
        longint cr, sr, cp, sp, cy, sy;
        t_quat  q;
        half_angle_cos_sin(a.roll, cr, sr);
        half_angle_cos_sin(a.pitch, cp, sp);
        half_angle_cos_sin(a.yaw, cy, sy);
        q.w = to_q15(round_q30(round_q30(cr, cp), cy) + round_q30(round_q30(sr, sp), sy));
        q.x = to_q15(round_q30(round_q30(sr, cp), cy) - round_q30(round_q30(cr, sp), sy));
        q.y = to_q15(round_q30(round_q30(cr, sp), cy) + round_q30(round_q30(sr, cp), sy));
        q.z = to_q15(round_q30(round_q30(cr, cp), sy) - round_q30(round_q30(sr, sp), cy));
        return q;
    endfunction

    function automatic logic signed [AngW-1:0] random_angle();
        case ($urandom_range(0, 3))
            0: return AngW'($urandom);
            1: return AngW'($signed($urandom_range(0, 2 * 23040)) - 23040); // +/-180 deg
            2: return AngW'($signed($urandom_range(0, 1024)) - 512);       // near zero
            default: return AngW'(($urandom_range(0, 7) * 45 * 128)
                                  + $signed($urandom_range(0, 4)) - 2);    // near 45 deg steps
        endcase
    endfunction

    // Driver: presents the next pending request, holding it until it is taken.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                expected_quats.push_back(predict_quat({i_roll_deg, i_pitch_deg, i_yaw_deg}));
                requests_sent++;
            end
            if (!i_valid || o_ready) begin
                if (pending_angles.size() > 0 && (calm_stretch || $urandom_range(0, 99) >= 24)) begin
                    t_angles a;
                    a = pending_angles.pop_front();
                    i_valid <= 1'b1;
                    i_roll_deg <= a.roll;
                    i_pitch_deg <= a.pitch;
                    i_yaw_deg <= a.yaw;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            // The receiver stalls at random, except during the calm stretch.
            i_ready <= calm_stretch || ($urandom_range(0, 99) >= 24);
        end
    end

    // Monitor: compares every accepted quaternion with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_quats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected quaternion w=%0d x=%0d y=%0d z=%0d",
                             o_quat_w, o_quat_x, o_quat_y, o_quat_z);
            end else begin
                t_quat e;
                e = expected_quats.pop_front();
                quats_checked++;
                if (e.w !== o_quat_w || e.x !== o_quat_x ||
                    e.y !== o_quat_y || e.z !== o_quat_z) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"quaternion %0d: expected w=%0d x=%0d y=%0d z=%0d, ",
                                  "got w=%0d x=%0d y=%0d z=%0d"},
                                 quats_checked, e.w, e.x, e.y, e.z,
                                 o_quat_w, o_quat_x, o_quat_y, o_quat_z);
                end
            end
        end
    end

    // Stimulus: directed angles first, then random ones.
    initial begin
        logic signed [AngW-1:0] corners[8] = '{16'sh0000, 16'sh7FFF, -16'sh8000, 16'sh0001,
            -16'sh0001, 16'sd11520, -16'sd23040, 16'sd23040};
        for (int i = 0; i < 8; i++)
            pending_angles.push_back('{corners[i], corners[(i + 3) % 8], corners[(i + 5) % 8]});
        // Quarter-turn rotations about each axis, then large and mixed angles.
        pending_angles.push_back('{16'sd11520, 16'sd0, 16'sd0});
        pending_angles.push_back('{16'sd0, 16'sd11520, 16'sd0});
        pending_angles.push_back('{16'sd0, 16'sd0, 16'sd11520});
        pending_angles.push_back('{16'sd0, 16'sd0, -16'sd11520});
        pending_angles.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
        pending_angles.push_back('{-16'sh8000, -16'sh8000, -16'sh8000});
        pending_angles.push_back('{16'sh5555, -16'sh5556, 16'sh2AAA});
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < NumRandom; i++)
            pending_angles.push_back('{random_angle(), random_angle(), random_angle()});
        // Run a stretch with no idling on either side in the middle of the run.
        wait (requests_sent >= 250);
        calm_stretch = 1;
        wait (requests_sent >= 400);
        calm_stretch = 0;
        wait (pending_angles.size() == 0 && !i_valid);
        wait (expected_quats.size() == 0);
        repeat (Stages + 20) @(posedge i_clk);
        $display("Checked %0d quaternions from %0d angle requests, with random idling",
                 quats_checked, requests_sent);
        $display("on both sides and a stretch of back-to-back traffic.");
        if (mismatches == 0 && expected_quats.size() == 0)
            $display("[euler_to_quaternion] OK");
        else
            $display("[euler_to_quaternion] ERROR");
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin
        #2ms;
        $display("timeout");
        $display("[euler_to_quaternion] ERROR");
        $finish;
    end
endmodule
